FILE: hw/rtl/rgb_line_offset_realigner_top_macros.svh
// Assertion macros for the RGB line offset realigner.
// Used by rgb_line_offset_realigner_top; no other dependencies.
`ifndef RGB_LINE_OFFSET_REALIGNER_TOP_MACROS_SVH
`define RGB_LINE_OFFSET_REALIGNER_TOP_MACROS_SVH

// Same-cycle implication
`define RLR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define RLR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/rlr_pkg.sv
// Shared types and constants for the RGB line offset realigner.
// No dependencies.
package rlr_pkg;

    localparam int MAX_PIXELS_DEF = 2048;
    localparam int MAX_LAG_DEF    = 7;
    localparam int PLANES         = 3;

    localparam int DATA_W     = 8;
    localparam int CFG_PPL_W  = 12;
    localparam int CFG_LAG_W  = 3;
    localparam int CFG_DATA_W = 12;
    localparam int CFG_IDX_W  = 8;

    localparam logic [CFG_IDX_W-1:0] REG_PPL       = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_OFF_RED   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_OFF_GREEN = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_OFF_BLUE  = CFG_IDX_W'(3);

    localparam logic [CFG_PPL_W-1:0] PPL_RESET = CFG_PPL_W'(2048);

    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_PULL = 1'b1;

    typedef enum logic [1:0] {
        ST_PUSH_OK      = 2'd0,
        ST_PUSH_REFUSED = 2'd1,
        ST_PULL_DATA    = 2'd2,
        ST_PULL_EMPTY   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        PL_RED   = 2'd0,
        PL_GREEN = 2'd1,
        PL_BLUE  = 2'd2
    } t_plane;

    typedef struct packed {
        t_status status;
        logic    line_end;
    } t_meta;

endpackage

FILE: hw/rtl/rlr_req_if.sv
// Request channel: push or pull transaction into the realigner.
// Depends on rlr_pkg.
interface rlr_req_if;
    logic                       valid;
    logic                       ready;
    logic                       req_type;
    logic [rlr_pkg::DATA_W-1:0] data_byte;

    modport source (output valid, output req_type, output data_byte, input ready);
    modport sink   (input valid, input req_type, input data_byte, output ready);
endinterface

FILE: hw/rtl/rlr_rsp_if.sv
// Response channel: one result transaction per accepted request.
// Depends on rlr_pkg.
interface rlr_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 status;
    logic [rlr_pkg::DATA_W-1:0] out_byte;
    logic                       line_end;

    modport source (output valid, output status, output out_byte, output line_end,
                    input ready);
    modport sink   (input valid, input status, input out_byte, input line_end,
                    output ready);
endinterface

FILE: hw/rtl/rlr_store.sv
// Line store: single-port-write, registered-read byte memory.
// Depends on rlr_pkg.
module rlr_store #(
    parameter int DEPTH = 49152,
    parameter int AW    = 16
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [AW-1:0]              i_waddr,
    input  logic [rlr_pkg::DATA_W-1:0] i_wdata,
    input  logic                       i_re,
    input  logic [AW-1:0]              i_raddr,
    output logic [rlr_pkg::DATA_W-1:0] o_rdata
);
    import rlr_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_q <= mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

FILE: hw/rtl/rlr_ctrl.sv
// Realigner control: config registers, write/read pointers, line ring
// bookkeeping and store address generation. Depends on rlr_pkg.
module rlr_ctrl #(
    parameter int MAX_PIXELS = rlr_pkg::MAX_PIXELS_DEF,
    parameter int MAX_LAG    = rlr_pkg::MAX_LAG_DEF,
    parameter int AW         = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rlr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rlr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_acc,
    input  logic                           i_req_type,
    input  logic [rlr_pkg::DATA_W-1:0]     i_data,
    output logic                           o_mem_we,
    output logic [AW-1:0]                  o_mem_waddr,
    output logic [rlr_pkg::DATA_W-1:0]     o_mem_wdata,
    output logic                           o_mem_re,
    output logic [AW-1:0]                  o_mem_raddr,
    output rlr_pkg::t_meta                 o_meta
);
    import rlr_pkg::*;

    localparam int STRIDE = PLANES * MAX_PIXELS;
    localparam int PW     = $clog2(MAX_PIXELS + 1);
    localparam int PXW    = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int LW     = $clog2(STRIDE + 1);
    localparam int SW     = (MAX_LAG > 0) ? $clog2(MAX_LAG + 1) : 1;
    localparam int DW     = $clog2(MAX_LAG + 2);

    function automatic logic [SW-1:0] sat_lag(input logic [CFG_LAG_W-1:0] v);
        if (int'(v) > MAX_LAG) begin
            return SW'(MAX_LAG);
        end
        return SW'(v);
    endfunction

    logic [CFG_PPL_W-1:0] r_ppl;
    logic [CFG_LAG_W-1:0] r_off_r, r_off_g, r_off_b;

    logic [LW-1:0]  r_wr_pos,   n_wr_pos;
    logic [SW-1:0]  r_wr_slot,  n_wr_slot;
    logic [DW-1:0]  r_loaded,   n_loaded;
    logic [SW-1:0]  r_oldest,   n_oldest;
    logic [PXW-1:0] r_rd_pixel, n_rd_pixel;
    t_plane         r_rd_plane, n_rd_plane;
    logic           r_pending,  n_pending;

    logic [SW-1:0] lag_r, lag_g, lag_b, lag_max, lag_sel;
    logic [DW-1:0] depth;
    logic [PW-1:0] p_eff;
    logic [LW-1:0] line_bytes, wr_pos_inc, plane_base, rd_off;
    logic          wr_eol;
    logic [DW-1:0] slot_inc, loaded_inc;
    logic [SW-1:0] wr_slot_nx;
    logic [SW:0]   rd_sum;
    logic [SW-1:0] rd_slot;
    logic          rd_last;
    logic          cfg_hit;
    logic          is_push;

    assign lag_r = sat_lag(r_off_r);
    assign lag_g = sat_lag(r_off_g);
    assign lag_b = sat_lag(r_off_b);

    always_comb begin
        lag_max = lag_r;
        if (lag_g > lag_max) begin
            lag_max = lag_g;
        end
        if (lag_b > lag_max) begin
            lag_max = lag_b;
        end
    end

    assign depth = DW'(lag_max) + DW'(1);

    always_comb begin
        if (r_ppl == '0) begin
            p_eff = PW'(1);
        end else if (int'(r_ppl) > MAX_PIXELS) begin
            p_eff = PW'(MAX_PIXELS);
        end else begin
            p_eff = PW'(r_ppl);
        end
    end

    assign line_bytes = LW'(p_eff) + (LW'(p_eff) << 1);

    // write side
    assign wr_pos_inc = r_wr_pos + LW'(1);
    assign wr_eol     = (wr_pos_inc >= line_bytes);
    assign slot_inc   = DW'(r_wr_slot) + DW'(1);
    assign wr_slot_nx = (slot_inc == depth) ? '0 : SW'(slot_inc);
    assign loaded_inc = (r_loaded < depth) ? r_loaded + DW'(1) : r_loaded;

    // read side
    always_comb begin
        unique case (r_rd_plane)
            PL_RED: begin
                lag_sel    = lag_r;
                plane_base = '0;
            end
            PL_GREEN: begin
                lag_sel    = lag_g;
                plane_base = LW'(p_eff);
            end
            PL_BLUE: begin
                lag_sel    = lag_b;
                plane_base = LW'(p_eff) << 1;
            end
            default: begin
                lag_sel    = lag_r;
                plane_base = '0;
            end
        endcase
    end

    assign rd_sum  = (SW+1)'(r_oldest) + (SW+1)'(lag_sel);
    assign rd_slot = (rd_sum >= (SW+1)'(depth)) ? SW'(rd_sum - (SW+1)'(depth))
                                                : SW'(rd_sum);
    assign rd_off  = LW'(r_rd_pixel) + plane_base;
    assign rd_last = (r_rd_plane == PL_BLUE) && (PW'(r_rd_pixel) == p_eff - PW'(1));

    assign o_mem_waddr = AW'(r_wr_slot) * AW'(STRIDE) + AW'(r_wr_pos);
    assign o_mem_raddr = AW'(rd_slot) * AW'(STRIDE) + AW'(rd_off);
    assign o_mem_wdata = i_data;

    assign is_push  = (i_req_type == REQ_PUSH);
    assign o_mem_we = i_acc && is_push && !r_pending;
    assign o_mem_re = i_acc && !is_push && r_pending;

    always_comb begin
        o_meta.line_end = 1'b0;
        if (is_push) begin
            o_meta.status = r_pending ? ST_PUSH_REFUSED : ST_PUSH_OK;
        end else if (r_pending) begin
            o_meta.status   = ST_PULL_DATA;
            o_meta.line_end = rd_last;
        end else begin
            o_meta.status = ST_PULL_EMPTY;
        end
    end

    always_comb begin
        n_wr_pos   = r_wr_pos;
        n_wr_slot  = r_wr_slot;
        n_loaded   = r_loaded;
        n_oldest   = r_oldest;
        n_rd_pixel = r_rd_pixel;
        n_rd_plane = r_rd_plane;
        n_pending  = r_pending;
        if (o_mem_we) begin
            if (wr_eol) begin
                n_wr_pos  = '0;
                n_wr_slot = wr_slot_nx;
                n_loaded  = loaded_inc;
                if (loaded_inc >= depth) begin
                    n_pending  = 1'b1;
                    n_oldest   = wr_slot_nx;
                    n_rd_pixel = '0;
                    n_rd_plane = PL_RED;
                end
            end else begin
                n_wr_pos = wr_pos_inc;
            end
        end else if (o_mem_re) begin
            if (rd_last) begin
                n_pending  = 1'b0;
                n_rd_pixel = '0;
                n_rd_plane = PL_RED;
            end else begin
                unique case (r_rd_plane)
                    PL_RED:   n_rd_plane = PL_GREEN;
                    PL_GREEN: n_rd_plane = PL_BLUE;
                    PL_BLUE: begin
                        n_rd_plane = PL_RED;
                        n_rd_pixel = r_rd_pixel + PXW'(1);
                    end
                    default:  n_rd_plane = PL_RED;
                endcase
            end
        end
    end

    assign cfg_hit = i_cfg_we && (i_cfg_idx == REG_PPL || i_cfg_idx == REG_OFF_RED ||
                                  i_cfg_idx == REG_OFF_GREEN || i_cfg_idx == REG_OFF_BLUE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ppl      <= PPL_RESET;
            r_off_r    <= '0;
            r_off_g    <= '0;
            r_off_b    <= '0;
            r_wr_pos   <= '0;
            r_wr_slot  <= '0;
            r_loaded   <= '0;
            r_oldest   <= '0;
            r_rd_pixel <= '0;
            r_rd_plane <= PL_RED;
            r_pending  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_PPL) begin
                    r_ppl <= i_cfg_data[CFG_PPL_W-1:0];
                end
                if (i_cfg_idx == REG_OFF_RED) begin
                    r_off_r <= i_cfg_data[CFG_LAG_W-1:0];
                end
                if (i_cfg_idx == REG_OFF_GREEN) begin
                    r_off_g <= i_cfg_data[CFG_LAG_W-1:0];
                end
                if (i_cfg_idx == REG_OFF_BLUE) begin
                    r_off_b <= i_cfg_data[CFG_LAG_W-1:0];
                end
            end
            if (cfg_hit) begin
                r_wr_pos   <= '0;
                r_wr_slot  <= '0;
                r_loaded   <= '0;
                r_oldest   <= '0;
                r_rd_pixel <= '0;
                r_rd_plane <= PL_RED;
                r_pending  <= 1'b0;
            end else begin
                r_wr_pos   <= n_wr_pos;
                r_wr_slot  <= n_wr_slot;
                r_loaded   <= n_loaded;
                r_oldest   <= n_oldest;
                r_rd_pixel <= n_rd_pixel;
                r_rd_plane <= n_rd_plane;
                r_pending  <= n_pending;
            end
        end
    end

endmodule

FILE: hw/rtl/rgb_line_offset_realigner_top.sv
// RGB line offset realigner: top level with line store and result pipeline.
// Depends on rlr_pkg, rlr_req_if, rlr_rsp_if, rlr_ctrl, rlr_store and the macros header.
//
// Usage:
//   i_req carries one transaction per request: req_type 0 pushes data_byte as the
//   next planar byte (red plane, green plane, blue plane of a line), req_type 1
//   pulls the next interleaved R,G,B byte of the pending output line.
//   o_rsp returns exactly one transaction per request: status, out_byte, line_end.
//   The config port (i_cfg_we, i_cfg_idx, i_cfg_data) sets line length and per-color
//   line lags; any write to a known register restarts the line stream. Write it
//   only while no request is in flight.
//   A result passes the registered store read in the read stage and then the output
//   register before it shows on o_rsp. Throughput: one request per cycle while
//   i_req.ready is high; each request is at most one store access.
//   Reset clears pointers and registers; the store itself is not cleared, no
//   clearing pass is run, and the block takes requests right after reset.
//   When o_rsp stalls, one result sits in the output register and one more in
//   the read stage; i_req.ready drops only when both are full.
`include "rgb_line_offset_realigner_top_macros.svh"

module rgb_line_offset_realigner_top #(
    parameter int MAX_PIXELS = rlr_pkg::MAX_PIXELS_DEF,
    parameter int MAX_LAG    = rlr_pkg::MAX_LAG_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rlr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rlr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    rlr_req_if.sink                        i_req,
    rlr_rsp_if.source                      o_rsp
);
    import rlr_pkg::*;

    localparam int DEPTH = (MAX_LAG + 1) * PLANES * MAX_PIXELS;
    localparam int AW    = $clog2(DEPTH);

    logic              acc;
    logic              mem_we, mem_re;
    logic [AW-1:0]     mem_waddr, mem_raddr;
    logic [DATA_W-1:0] mem_wdata, mem_rdata;
    t_meta             meta;

    logic              r_s1_valid;
    t_meta             r_s1_meta;
    logic              r_out_valid;
    t_status           r_out_status;
    logic [DATA_W-1:0] r_out_byte;
    logic              r_out_last;
    logic              move;

    assign i_req.ready = !r_s1_valid || !r_out_valid || o_rsp.ready;
    assign acc         = i_req.valid && i_req.ready;
    assign move        = r_s1_valid && (!r_out_valid || o_rsp.ready);

    rlr_ctrl #(
        .MAX_PIXELS (MAX_PIXELS),
        .MAX_LAG    (MAX_LAG),
        .AW         (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_acc       (acc),
        .i_req_type  (i_req.req_type),
        .i_data      (i_req.data_byte),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .o_meta      (meta)
    );

    rlr_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // read stage: store data register holds while no new read is issued
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (acc) begin
            r_s1_valid <= 1'b1;
        end else if (move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_meta <= meta;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (move) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_out_status <= r_s1_meta.status;
            r_out_last   <= r_s1_meta.line_end;
            r_out_byte   <= (r_s1_meta.status == ST_PULL_DATA) ? mem_rdata : '0;
        end
    end

    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.status   = r_out_status;
    assign o_rsp.out_byte = r_out_byte;
    assign o_rsp.line_end = r_out_last;

    `RLR_ASSERT_IMP(a_zero_byte, i_clk, i_rst_n, o_rsp.valid && o_rsp.status != ST_PULL_DATA, o_rsp.out_byte == '0, "nonzero byte without pull data")
    `RLR_ASSERT_IMP(a_end_on_data, i_clk, i_rst_n, o_rsp.valid && o_rsp.line_end, o_rsp.status == ST_PULL_DATA, "line end without pull data")
    `RLR_ASSERT_NXT(a_acc_fills, i_clk, i_rst_n, acc, r_s1_valid, "accepted transaction lost in read stage")
    `RLR_ASSERT_NXT(a_stall_holds, i_clk, i_rst_n, r_s1_valid && r_out_valid && !o_rsp.ready, r_s1_valid && r_out_valid, "result dropped under stall")

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for rgb_line_offset_realigner_top: directed rows, then random traffic.
// Depends on rlr_pkg, rlr_req_if, rlr_rsp_if and the realigner RTL.
module tb_top;
    import rlr_pkg::*;

    localparam int STORE_BYTES    = (MAX_LAG_DEF + 1) * PLANES * MAX_PIXELS_DEF;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int N_ROWS         = 25;
    localparam int DRAIN_CYCLES   = 4;
    localparam logic [CFG_IDX_W-1:0] REG_NONE = CFG_IDX_W'(4);

    typedef struct packed {
        t_status    status;
        logic [7:0] out_byte;
        logic       line_end;
    } t_realign;

    typedef enum logic {ROW_REQ, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind             kind;
        logic                  req;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] val;
        logic                  typed;
        t_realign              exp;
    } t_stim_row;

    localparam t_realign EXP_OK      = '{ST_PUSH_OK, 8'h00, 1'b0};
    localparam t_realign EXP_REFUSED = '{ST_PUSH_REFUSED, 8'h00, 1'b0};
    localparam t_realign EXP_EMPTY   = '{ST_PULL_EMPTY, 8'h00, 1'b0};

    t_stim_row directed_rows [N_ROWS] = '{
        '{ROW_REQ, REQ_PULL, REG_PPL, 12'h000, 1'b1, EXP_EMPTY},
        '{ROW_REQ, REQ_PUSH, REG_PPL, 12'h000, 1'b1, EXP_OK},
        '{ROW_REQ, REQ_PUSH, REG_PPL, 12'h0FF, 1'b1, EXP_OK},
        '{ROW_CFG, REQ_PUSH, REG_PPL, 12'h001, 1'b0, EXP_OK},
        '{ROW_REQ, REQ_PUSH, REG_PPL, 12'h0A5, 1'b1, EXP_OK},
        '{ROW_REQ, REQ_PUSH, REG_PPL, 12'h05A, 1'b1, EXP_OK},
        '{ROW_REQ, REQ_PUSH, REG_PPL, 12'h03C, 1'b1, EXP_OK},
        '{ROW_REQ, REQ_PUSH, REG_PPL, 12'h096, 1'b1, EXP_REFUSED},
        '{ROW_CFG, REQ_PUSH, REG_NONE, 12'h0FF, 1'b0, EXP_OK},
        '{ROW_REQ, REQ_PULL, REG_PPL, 12'h000, 1'b1, '{ST_PULL_DATA, 8'hA5, 1'b0}},
        '{ROW_REQ, REQ_PULL, REG_PPL, 12'h000, 1'b1, '{ST_PULL_DATA, 8'h5A, 1'b0}},
        '{ROW_REQ, REQ_PULL, REG_PPL, 12'h000, 1'b1, '{ST_PULL_DATA, 8'h3C, 1'b1}},
        '{ROW_REQ, REQ_PULL, REG_PPL, 12'h000, 1'b1, EXP_EMPTY},
        '{ROW_CFG, REQ_PUSH, REG_PPL, 12'h000, 1'b0, EXP_OK},
        '{ROW_CFG, REQ_PUSH, REG_OFF_BLUE, 12'h001, 1'b0, EXP_OK},
        '{ROW_REQ, REQ_PUSH, REG_PPL, 12'h001, 1'b0, EXP_OK},
        '{ROW_REQ, REQ_PUSH, REG_PPL, 12'h002, 1'b0, EXP_OK},
        '{ROW_REQ, REQ_PUSH, REG_PPL, 12'h003, 1'b0, EXP_OK},
        '{ROW_REQ, REQ_PUSH, REG_PPL, 12'h004, 1'b0, EXP_OK},
        '{ROW_REQ, REQ_PUSH, REG_PPL, 12'h005, 1'b0, EXP_OK},
        '{ROW_REQ, REQ_PUSH, REG_PPL, 12'h006, 1'b0, EXP_OK},
        '{ROW_REQ, REQ_PULL, REG_PPL, 12'h000, 1'b0, EXP_OK},
        '{ROW_REQ, REQ_PULL, REG_PPL, 12'h000, 1'b0, EXP_OK},
        '{ROW_REQ, REQ_PULL, REG_PPL, 12'h000, 1'b0, EXP_OK},
        '{ROW_REQ, REQ_PUSH, REG_PPL, 12'h007, 1'b0, EXP_OK}
    };

    int gap_tbl   [4] = '{0, 57, 0, 14};
    int stall_tbl [4] = '{0, 0, 57, 14};

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    rlr_req_if req_if ();
    rlr_rsp_if rsp_if ();

    rgb_line_offset_realigner_top uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_req      (req_if),
        .o_rsp      (rsp_if)
    );

    // shadow of the realigner
    logic [7:0]            line_mem [STORE_BYTES];
    int unsigned           wr_pos, wr_slot, loaded, oldest, rd_pos;
    bit                    line_pend;
    logic [CFG_PPL_W-1:0]  cfg_ppl = PPL_RESET;
    logic [CFG_LAG_W-1:0]  lag_r = '0, lag_g = '0, lag_b = '0;

    t_realign realign_q [$];
    t_realign row_exp;
    bit       row_typed;
    int       gap_pct, stall_pct;
    int       err_count, n_req, lines_out, n_cfg, quiet_cycles;

    function automatic int unsigned plane_lag(t_plane pl);
        int unsigned v;
        case (pl)
            PL_RED:   v = lag_r;
            PL_GREEN: v = lag_g;
            default:  v = lag_b;
        endcase
        return (v > MAX_LAG_DEF) ? MAX_LAG_DEF : v;
    endfunction

    function automatic void apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
        bit known;
        known = 1'b1;
        case (idx)
            REG_PPL:       cfg_ppl = v[CFG_PPL_W-1:0];
            REG_OFF_RED:   lag_r = v[CFG_LAG_W-1:0];
            REG_OFF_GREEN: lag_g = v[CFG_LAG_W-1:0];
            REG_OFF_BLUE:  lag_b = v[CFG_LAG_W-1:0];
            default:       known = 1'b0;
        endcase
        if (known) begin
            wr_pos = 0;
            wr_slot = 0;
            loaded = 0;
            oldest = 0;
            rd_pos = 0;
            line_pend = 1'b0;
        end
    endfunction

    function automatic t_realign predict_realign(logic rt, logic [7:0] d);
        int unsigned p, line_bytes, depth, slot, pos, rp, pix;
        t_plane pl;
        t_realign r;
        r = EXP_OK;
        if (cfg_ppl == 0) p = 1;
        else p = (cfg_ppl > MAX_PIXELS_DEF) ? MAX_PIXELS_DEF : cfg_ppl;
        line_bytes = PLANES * p;
        depth = plane_lag(PL_RED);
        if (plane_lag(PL_GREEN) > depth) depth = plane_lag(PL_GREEN);
        if (plane_lag(PL_BLUE) > depth) depth = plane_lag(PL_BLUE);
        depth = depth + 1;
        if (rt == REQ_PUSH) begin
            if (line_pend) begin
                r.status = ST_PUSH_REFUSED;
            end else begin
                slot = wr_slot % depth;
                pos = wr_pos % line_bytes;
                line_mem[slot * PLANES * MAX_PIXELS_DEF + pos] = d;
                pos++;
                if (pos >= line_bytes) begin
                    pos = 0;
                    slot = (slot + 1) % depth;
                    if (loaded < depth) loaded++;
                    if (loaded >= depth) begin
                        line_pend = 1'b1;
                        oldest = slot;
                        rd_pos = 0;
                    end
                end
                wr_pos = pos;
                wr_slot = slot;
            end
        end else if (line_pend) begin
            rp = rd_pos % line_bytes;
            pix = rp / PLANES;
            pl = t_plane'(rp % PLANES);
            slot = (oldest + plane_lag(pl)) % depth;
            r.out_byte = line_mem[slot * PLANES * MAX_PIXELS_DEF + int'(pl) * p + pix];
            r.status = ST_PULL_DATA;
            rp++;
            if (rp >= line_bytes) begin
                rp = 0;
                r.line_end = 1'b1;
                line_pend = 1'b0;
                lines_out++;
            end
            rd_pos = rp;
        end else begin
            r.status = ST_PULL_EMPTY;
        end
        return r;
    endfunction

    function automatic void note_mismatch(string what, t_realign want);
        err_count++;
        if (err_count <= 10)
            $display("%0t: %s: expected status %0d byte %02h end %0b, got status %0d byte %02h end %0b",
                     $realtime, what, want.status, want.out_byte, want.line_end,
                     rsp_if.status, rsp_if.out_byte, rsp_if.line_end);
    endfunction

    always #5 clk = ~clk;

    always @(negedge clk) begin
        rsp_if.ready = ($urandom_range(99) >= stall_pct);
    end

    // predict on each accepted request, check each accepted result
    always @(posedge clk) begin
        t_realign want;
        if (rst_n) begin
            if (cfg_we) apply_cfg(cfg_idx, cfg_data);
            if (req_if.valid && req_if.ready) begin
                want = predict_realign(req_if.req_type, req_if.data_byte);
                if (row_typed) want = row_exp;
                realign_q.push_back(want);
                n_req++;
            end
            if (rsp_if.valid && rsp_if.ready) begin
                if (realign_q.size() == 0) begin
                    note_mismatch("unexpected transaction", EXP_OK);
                end else begin
                    want = realign_q.pop_front();
                    if (want.status != rsp_if.status || want.out_byte != rsp_if.out_byte ||
                        want.line_end != rsp_if.line_end)
                        note_mismatch("mismatch", want);
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || cfg_we || (req_if.valid && req_if.ready) ||
            (rsp_if.valid && rsp_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_req(logic rt, logic [7:0] d, bit typed, t_realign t);
        while ($urandom_range(99) < gap_pct) begin
            req_if.valid = 1'b0;
            @(negedge clk);
        end
        req_if.valid = 1'b1;
        req_if.req_type = rt;
        req_if.data_byte = d;
        row_typed = typed;
        row_exp = t;
        @(posedge clk);
        while (!req_if.ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        req_if.valid = 1'b0;
        while (realign_q.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
        cfg_we = 1'b1;
        cfg_idx = idx;
        cfg_data = v;
        n_cfg++;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    function automatic logic [CFG_DATA_W-1:0] lag_value();
        logic [CFG_LAG_W-1:0] lag;
        lag = ($urandom_range(3) == 0) ? CFG_LAG_W'(7) : CFG_LAG_W'($urandom_range(7));
        return {9'($urandom_range(511)), lag};
    endfunction

    task automatic randomize_cfg();
        int pick;
        logic [CFG_PPL_W-1:0] ppl;
        pick = $urandom_range(99);
        if (pick < 60) ppl = CFG_PPL_W'($urandom_range(2));
        else if (pick < 90) ppl = CFG_PPL_W'($urandom_range(6, 3));
        else ppl = CFG_PPL_W'($urandom_range(16, 7));
        write_reg(REG_PPL, ppl);
        if ($urandom_range(3) != 0) write_reg(REG_OFF_RED, lag_value());
        if ($urandom_range(3) != 0) write_reg(REG_OFF_GREEN, lag_value());
        if ($urandom_range(3) != 0) write_reg(REG_OFF_BLUE, lag_value());
        if ($urandom_range(3) == 0)
            write_reg(CFG_IDX_W'($urandom_range(255, REG_NONE)), CFG_DATA_W'($urandom));
    endtask

    // mostly well-formed: fill lines while free, drain while a line is pending
    task automatic run_traffic(int n_min, int n_lines);
        int sent, lines0;
        logic rt;
        sent = 0;
        lines0 = lines_out;
        while (sent < n_min || lines_out - lines0 < n_lines) begin
            if (line_pend) rt = ($urandom_range(99) < 85) ? REQ_PULL : REQ_PUSH;
            else rt = ($urandom_range(99) < 85) ? REQ_PUSH : REQ_PULL;
            send_req(rt, 8'($urandom_range(255)), 1'b0, EXP_OK);
            sent++;
        end
        req_if.valid = 1'b0;
    endtask

    initial begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        req_if.valid = 1'b0;
        req_if.req_type = REQ_PUSH;
        req_if.data_byte = '0;
        rsp_if.ready = 1'b0;
        gap_pct = 0;
        stall_pct = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CFG) begin
                wait_drained();
                write_reg(directed_rows[i].idx, directed_rows[i].val);
            end else begin
                send_req(directed_rows[i].req, directed_rows[i].val[7:0],
                         directed_rows[i].typed, directed_rows[i].exp);
            end
        end

        for (int m = 0; m < 4; m++) begin
            gap_pct = gap_tbl[m];
            stall_pct = stall_tbl[m];
            for (int k = 0; k < 2; k++) begin
                wait_drained();
                randomize_cfg();
                run_traffic(80, 2);
            end
        end

        // over-range length: partial line at the saturated maximum
        gap_pct = 0;
        stall_pct = 0;
        wait_drained();
        write_reg(REG_OFF_RED, '0);
        write_reg(REG_OFF_GREEN, '0);
        write_reg(REG_OFF_BLUE, '0);
        write_reg(REG_PPL, '1);
        run_traffic(32, 0);

        wait_drained();
        $display("covered %0d request transactions, %0d realigned lines, %0d register writes",
                 n_req, lines_out, n_cfg);
        $display("line lengths 0 to 16 plus an over-range length, lags 0 to 7, %0d mismatches",
                 err_count);
        if (err_count == 0 && realign_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

FILE: rgb_line_offset_realigner_top.f
+incdir+hw/rtl
hw/rtl/rlr_pkg.sv
hw/rtl/rlr_req_if.sv
hw/rtl/rlr_rsp_if.sv
hw/rtl/rlr_store.sv
hw/rtl/rlr_ctrl.sv
hw/rtl/rgb_line_offset_realigner_top.sv
verif/tb_top.sv
